/* sv/crc32rfp_pkg.sv */
// ----------------------------------------------------------------------------
// crc32rfp_pkg
// Types, constants and the bytewise CRC-32 function shared by the record
// frame parser modules.
// ----------------------------------------------------------------------------
package crc32rfp_pkg;

    localparam logic [31:0] FRAME_MAGIC     = 32'h3143_534F;
    localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT        = 32'hFFFF_FFFF;
    localparam int unsigned PREAMBLE_BYTES  = 12;
    localparam int unsigned HEADER_BYTES    = 4 + 4 + 4 + 1 + 2;
    localparam logic [15:0] MAX_BODY_RESET  = 16'd255;

    // Header byte offsets
    localparam logic [3:0] HDR_ORIGIN_POS = 4'd4;
    localparam logic [3:0] HDR_DEST_POS   = 4'd8;
    localparam logic [3:0] HDR_FLAGS_POS  = 4'd12;
    localparam logic [3:0] HDR_LENLO_POS  = 4'd13;

    typedef enum logic [2:0] {
        PH_PREAMBLE = 3'd0,
        PH_HEADER   = 3'd1,
        PH_BODY     = 3'd2,
        PH_TRAILING = 3'd3,
        PH_HALTED   = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_MAGIC   = 3'd2,
        ST_CRC     = 3'd3,
        ST_TRUNC   = 3'd4,
        ST_TOOLONG = 3'd5,
        ST_TRAIL   = 3'd6
    } status_t;

    typedef struct packed {
        logic        header_valid;
        logic [31:0] msg_id;
        logic [31:0] origin_node;
        logic [31:0] dest_node;
        logic [7:0]  record_flags;
        logic [15:0] body_length;
        logic        body_valid;
        logic [7:0]  body_byte;
        logic        body_last;
        logic        frame_done;
        logic [2:0]  frame_status;
    } result_t;

    // Reflected CRC-32 update by one byte, eight shift/xor steps
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

/* sv/crc32rfp_core.sv */
// ----------------------------------------------------------------------------
// crc32rfp_core
// Frame parsing state and the per-byte next-state / result logic. State
// advances on each accepted beat; the result is combinational from the
// current state and the accepted byte.
// ----------------------------------------------------------------------------
module crc32rfp_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    input  logic [15:0]           max_body_length,
    output crc32rfp_pkg::result_t result
);

    crc32rfp_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  byte_position_reg, byte_position_next;
    logic [31:0] magic_shift_reg, magic_shift_next;
    logic [31:0] records_left_reg, records_left_next;
    logic [31:0] expected_crc_reg, expected_crc_next;
    logic [31:0] running_crc_reg, running_crc_next;
    logic [31:0] header_id_reg, header_id_next;
    logic [31:0] header_origin_reg, header_origin_next;
    logic [31:0] header_dest_reg, header_dest_next;
    logic [7:0]  header_flags_reg, header_flags_next;
    logic [7:0]  length_low_reg, length_low_next;
    logic [15:0] body_left_reg, body_left_next;
    crc32rfp_pkg::status_t first_error_reg, first_error_next;

    logic [3:0]  pos_inc;
    logic [15:0] body_len;
    logic [15:0] body_left_dec;
    logic [31:0] records_dec;
    logic        is_short;
    crc32rfp_pkg::status_t status;

    assign pos_inc       = byte_position_reg + 4'd1;
    assign body_len      = {data_byte, length_low_reg};
    assign body_left_dec = body_left_reg - 16'd1;
    assign records_dec   = records_left_reg - 32'd1;

    // Next state and result for the current byte
    always_comb
    begin
        phase_next         = phase_reg;
        byte_position_next = byte_position_reg;
        magic_shift_next   = magic_shift_reg;
        records_left_next  = records_left_reg;
        expected_crc_next  = expected_crc_reg;
        running_crc_next   = running_crc_reg;
        header_id_next     = header_id_reg;
        header_origin_next = header_origin_reg;
        header_dest_next   = header_dest_reg;
        header_flags_next  = header_flags_reg;
        length_low_next    = length_low_reg;
        body_left_next     = body_left_reg;
        first_error_next   = first_error_reg;
        is_short           = 1'b0;
        status             = crc32rfp_pkg::ST_OK;
        result             = '0;

        if (phase_reg == crc32rfp_pkg::PH_PREAMBLE)
        begin
            // little-endian words shift in from the top
            if (byte_position_reg < crc32rfp_pkg::HDR_ORIGIN_POS)
                magic_shift_next = {data_byte, magic_shift_reg[31:8]};
            else if (byte_position_reg < crc32rfp_pkg::HDR_DEST_POS)
                records_left_next = {data_byte, records_left_reg[31:8]};
            else
                expected_crc_next = {data_byte, expected_crc_reg[31:8]};
            if (pos_inc >= 4'(crc32rfp_pkg::PREAMBLE_BYTES))
            begin
                byte_position_next = 4'd0;
                phase_next = (records_left_next != 32'd0) ? crc32rfp_pkg::PH_HEADER
                                                          : crc32rfp_pkg::PH_TRAILING;
            end
            else
            begin
                byte_position_next = pos_inc;
                is_short = last_byte;
            end
        end
        else
        begin
            running_crc_next = crc32rfp_pkg::crc_byte(running_crc_reg, data_byte);
            case (phase_reg)
                crc32rfp_pkg::PH_HEADER:
                begin
                    if (byte_position_reg < crc32rfp_pkg::HDR_ORIGIN_POS)
                        header_id_next = {data_byte, header_id_reg[31:8]};
                    else if (byte_position_reg < crc32rfp_pkg::HDR_DEST_POS)
                        header_origin_next = {data_byte, header_origin_reg[31:8]};
                    else if (byte_position_reg < crc32rfp_pkg::HDR_FLAGS_POS)
                        header_dest_next = {data_byte, header_dest_reg[31:8]};
                    else if (byte_position_reg == crc32rfp_pkg::HDR_FLAGS_POS)
                        header_flags_next = data_byte;
                    else if (byte_position_reg == crc32rfp_pkg::HDR_LENLO_POS)
                        length_low_next = data_byte;

                    if ({1'b0, byte_position_reg} + 5'd1 < 5'(crc32rfp_pkg::HEADER_BYTES))
                    begin
                        byte_position_next = pos_inc;
                    end
                    else
                    begin
                        byte_position_next = 4'd0;
                        if (body_len > max_body_length)
                        begin
                            // oversize body: stop parsing, only the CRC runs on
                            if (first_error_reg == crc32rfp_pkg::ST_OK)
                                first_error_next = crc32rfp_pkg::ST_TOOLONG;
                            phase_next = crc32rfp_pkg::PH_HALTED;
                        end
                        else
                        begin
                            result.header_valid = 1'b1;
                            result.msg_id       = header_id_reg;
                            result.origin_node  = header_origin_reg;
                            result.dest_node    = header_dest_reg;
                            result.record_flags = header_flags_reg;
                            result.body_length  = body_len;
                            if (body_len == 16'd0)
                            begin
                                records_left_next = records_dec;
                                phase_next = (records_dec != 32'd0) ? crc32rfp_pkg::PH_HEADER
                                                                    : crc32rfp_pkg::PH_TRAILING;
                            end
                            else
                            begin
                                body_left_next = body_len;
                                phase_next     = crc32rfp_pkg::PH_BODY;
                            end
                        end
                    end
                end
                crc32rfp_pkg::PH_BODY:
                begin
                    result.body_valid = 1'b1;
                    result.body_byte  = data_byte;
                    body_left_next    = body_left_dec;
                    if (body_left_dec == 16'd0)
                    begin
                        result.body_last  = 1'b1;
                        records_left_next = records_dec;
                        phase_next = (records_dec != 32'd0) ? crc32rfp_pkg::PH_HEADER
                                                            : crc32rfp_pkg::PH_TRAILING;
                    end
                end
                crc32rfp_pkg::PH_TRAILING:
                begin
                    if (first_error_reg == crc32rfp_pkg::ST_OK)
                        first_error_next = crc32rfp_pkg::ST_TRAIL;
                end
                default:
                begin
                end
            endcase
        end

        // Final status on the last byte, then back to the start of a frame
        if (last_byte)
        begin
            if (is_short)
                status = crc32rfp_pkg::ST_SHORT;
            else if (magic_shift_next != crc32rfp_pkg::FRAME_MAGIC)
                status = crc32rfp_pkg::ST_MAGIC;
            else if (~running_crc_next != expected_crc_next)
                status = crc32rfp_pkg::ST_CRC;
            else if (first_error_next != crc32rfp_pkg::ST_OK)
                status = first_error_next;
            else if (phase_next == crc32rfp_pkg::PH_HEADER ||
                     phase_next == crc32rfp_pkg::PH_BODY)
                status = crc32rfp_pkg::ST_TRUNC;
            else
                status = crc32rfp_pkg::ST_OK;
            result.frame_done   = 1'b1;
            result.frame_status = status;

            phase_next         = crc32rfp_pkg::PH_PREAMBLE;
            byte_position_next = 4'd0;
            magic_shift_next   = '0;
            records_left_next  = '0;
            expected_crc_next  = '0;
            running_crc_next   = crc32rfp_pkg::CRC_INIT;
            header_id_next     = '0;
            header_origin_next = '0;
            header_dest_next   = '0;
            header_flags_next  = '0;
            length_low_next    = '0;
            body_left_next     = '0;
            first_error_next   = crc32rfp_pkg::ST_OK;
        end
    end

    // Parser state registers, updated once per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= crc32rfp_pkg::PH_PREAMBLE;
            byte_position_reg <= 4'd0;
            magic_shift_reg   <= '0;
            records_left_reg  <= '0;
            expected_crc_reg  <= '0;
            running_crc_reg   <= crc32rfp_pkg::CRC_INIT;
            header_id_reg     <= '0;
            header_origin_reg <= '0;
            header_dest_reg   <= '0;
            header_flags_reg  <= '0;
            length_low_reg    <= '0;
            body_left_reg     <= '0;
            first_error_reg   <= crc32rfp_pkg::ST_OK;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            byte_position_reg <= byte_position_next;
            magic_shift_reg   <= magic_shift_next;
            records_left_reg  <= records_left_next;
            expected_crc_reg  <= expected_crc_next;
            running_crc_reg   <= running_crc_next;
            header_id_reg     <= header_id_next;
            header_origin_reg <= header_origin_next;
            header_dest_reg   <= header_dest_next;
            header_flags_reg  <= header_flags_next;
            length_low_reg    <= length_low_next;
            body_left_reg     <= body_left_next;
            first_error_reg   <= first_error_next;
        end
    end

endmodule

/* sv/crc32rfp_out_buf.sv */
// ----------------------------------------------------------------------------
// crc32rfp_out_buf
// Output register with a skid stage. Input stays ready while the output
// register holds a result, until the skid entry is also occupied.
// ----------------------------------------------------------------------------
module crc32rfp_out_buf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  crc32rfp_pkg::result_t load_data,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output crc32rfp_pkg::result_t out_data
);

    logic                  out_valid_reg, out_valid_next;
    logic                  skid_valid_reg, skid_valid_next;
    crc32rfp_pkg::result_t out_data_reg, out_data_next;
    crc32rfp_pkg::result_t skid_data_reg, skid_data_next;
    logic                  out_free;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Move skid into output when it drains; new beats fill a free output, else skid
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = load;
                out_data_next  = load_data;
            end
        end
        else if (load)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = load_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

/* sv/crc32_record_frame_parser.sv */
// ----------------------------------------------------------------------------
// crc32_record_frame_parser
// Byte-stream parser for a CRC-32 protected, length-prefixed record frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one frame byte per beat, with
//   last_byte marking the final byte of the frame. Output channel
//   (out_valid/out_ready) returns exactly one result beat per input beat:
//   a record header (header_valid), a body byte (body_valid, body_last),
//   and on the last byte frame_done with frame_status.
//   A result is registered in the output register, or in the skid stage
//   while the output stalls. Throughput: one byte per cycle while in_ready
//   is high; the 8-step bytewise CRC and field capture are combinational.
//   A one-entry skid stage behind the output register lets one more byte
//   be accepted while a result waits; with both full, in_ready drops until
//   out_ready drains a beat.
//   Reset clears the parser to the start of a frame and sets
//   max_body_length to 255. cfg_wr_en writes max_body_length from
//   cfg_wr_data; write it only while the block is idle.
//   After the last byte of a frame the parser returns to the start of a
//   frame, keeping max_body_length.
// ----------------------------------------------------------------------------
module crc32_record_frame_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        header_valid,
    output logic [31:0] msg_id,
    output logic [31:0] origin_node,
    output logic [31:0] dest_node,
    output logic [7:0]  record_flags,
    output logic [15:0] body_length,
    output logic        body_valid,
    output logic [7:0]  body_byte,
    output logic        body_last,
    output logic        frame_done,
    output logic [2:0]  frame_status
);

    logic [15:0]           max_body_length_reg;
    logic                  in_fire;
    crc32rfp_pkg::result_t core_result;
    crc32rfp_pkg::result_t out_result;

    assign in_fire = in_valid && in_ready;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_body_length_reg <= crc32rfp_pkg::MAX_BODY_RESET;
        else if (cfg_wr_en)
            max_body_length_reg <= cfg_wr_data;
    end

    crc32rfp_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (in_fire),
        .data_byte       (data_byte),
        .last_byte       (last_byte),
        .max_body_length (max_body_length_reg),
        .result          (core_result)
    );

    crc32rfp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_fire),
        .load_data (core_result),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_result)
    );

    // Result fields to ports
    assign header_valid = out_result.header_valid;
    assign msg_id       = out_result.msg_id;
    assign origin_node  = out_result.origin_node;
    assign dest_node    = out_result.dest_node;
    assign record_flags = out_result.record_flags;
    assign body_length  = out_result.body_length;
    assign body_valid   = out_result.body_valid;
    assign body_byte    = out_result.body_byte;
    assign body_last    = out_result.body_last;
    assign frame_done   = out_result.frame_done;
    assign frame_status = out_result.frame_status;

endmodule

/* sv/crc32rfp_checker.sv */
// ----------------------------------------------------------------------------
// crc32rfp_assert
// Port-level checks for the record frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module crc32rfp_assert (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       header_valid,
    input logic       body_valid,
    input logic       body_last,
    input logic       frame_done,
    input logic [2:0] frame_status
);

    // stalled result beat is held
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    // input only backs up once a result is waiting
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input not ready with empty output");

    // a byte is never both a header completion and a body byte
    a_header_body_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(header_valid && body_valid))
        else $error("header and body flagged on one beat");

    a_body_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && body_last |-> body_valid)
        else $error("body_last without body byte");

    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_done |-> frame_status == crc32rfp_pkg::ST_OK)
        else $error("status set before frame end");

endmodule

bind crc32_record_frame_parser crc32rfp_assert u_assert (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .header_valid (header_valid),
    .body_valid   (body_valid),
    .body_last    (body_last),
    .frame_done   (frame_done),
    .frame_status (frame_status)
);
